// File: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int COUNT_W    = 7;
    localparam int POOL_W     = 13;
    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PHYS_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIRT_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 2'd2;

    localparam logic [ADDR_W-1:0] PHYS_BASE_RST  = 32'h0020_0000;
    localparam logic [ADDR_W-1:0] VIRT_BASE_RST  = 32'hC010_0000;
    localparam logic [POOL_W-1:0] POOL_PAGES_RST = 13'd3840;

    // controller -> datapath
    typedef struct packed {
        logic clr;       // clear one entry of both maps
        logic latch_req; // capture the incoming request
        logic start_v;   // arm virtual scan from bit 0
        logic scan_v;    // virtual run search
        logic mark_v;    // set one bit of the virtual run
        logic start_p;   // arm physical scan from hint
        logic scan_p;    // physical free-bit search
        logic take_p;    // claim physical bit, load page result
        logic load_fail; // load failure result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic req_bad;
        logic v_found;
        logic v_end;
        logic mark_done;
        logic p_found;
        logic p_end;
        logic out_free;
        logic last_page;
    } sts_t;

endpackage

// File: design/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over virtual and physical usage bitmaps.
// ----------------------------------------------------------------------------
// Usage: s_ carries one request (page_count, user_request); m_ returns one
// result per mapped page (virtual/physical byte address, last on the final
// one), or a single failed result with zero addresses. A physical shortfall
// emits the pages mapped so far, then the failure result.
// Config writes (cfg_wr_en/cfg_addr/cfg_wr_data) take effect immediately and
// belong only between requests.
// Timing: the virtual run search reads one bit per cycle from bit 0 up to
// usable-1; marking sets the run one bit at a time; each page then scans
// the physical map from a first-free hint and then loads the result. The
// single-read-port bitmap memories set this pace. Only one request is in
// flight; s_ready is high when idle.
// Reset: a clearing pass zeroes both maps; s_ready is low throughout. A
// stalled m_ready holds the result register and the sequencer waits before
// loading the next page.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
    parameter int POOL_DEPTH        = 4096,
    parameter int MAX_REQUEST_PAGES = 64,
    parameter int PAGE_BYTES        = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bpa_pkg::ADDR_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bpa_pkg::COUNT_W-1:0]    s_page_count,
    input  logic                           s_user_request,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bpa_pkg::ADDR_W-1:0]     m_virt_page_addr,
    output logic [bpa_pkg::ADDR_W-1:0]     m_phys_page_addr,
    output logic                           m_failed,
    output logic                           m_last
);
    import bpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpa_datapath #(
        .POOL_DEPTH        (POOL_DEPTH),
        .MAX_REQUEST_PAGES (MAX_REQUEST_PAGES),
        .PAGE_BYTES        (PAGE_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_page_count     (s_page_count),
        .s_user_request   (s_user_request),
        .m_virt_page_addr (m_virt_page_addr),
        .m_phys_page_addr (m_phys_page_addr),
        .m_failed         (m_failed),
        .m_last           (m_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

// File: design/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clearing, run search, marking and per-page allocation.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bpa_pkg::sts_t sts,
    output bpa_pkg::cmd_t cmd
);
    import bpa_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b0_0000_0001,
        ST_IDLE  = 9'b0_0000_0010,
        ST_CHECK = 9'b0_0000_0100,
        ST_VSCAN = 9'b0_0000_1000,
        ST_VMARK = 9'b0_0001_0000,
        ST_PSTRT = 9'b0_0010_0000,
        ST_PSCAN = 9'b0_0100_0000,
        ST_PEMIT = 9'b0_1000_0000,
        ST_FAIL  = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.req_bad) begin
                    state_next = ST_FAIL;
                end else begin
                    cmd.start_v = 1'b1;
                    state_next  = ST_VSCAN;
                end
            end
            ST_VSCAN: begin
                cmd.scan_v = 1'b1;
                if (sts.v_found)    state_next = ST_VMARK;
                else if (sts.v_end) state_next = ST_FAIL;
            end
            ST_VMARK: begin
                cmd.mark_v = 1'b1;
                if (sts.mark_done) state_next = ST_PSTRT;
            end
            ST_PSTRT: begin
                cmd.start_p = 1'b1;
                state_next  = ST_PSCAN;
            end
            ST_PSCAN: begin
                cmd.scan_p = 1'b1;
                if (sts.p_found)    state_next = ST_PEMIT;
                else if (sts.p_end) state_next = ST_FAIL;
            end
            ST_PEMIT: begin
                if (sts.out_free) begin
                    cmd.take_p = 1'b1;
                    state_next = sts.last_page ? ST_IDLE : ST_PSTRT;
                end
            end
            ST_FAIL: begin
                if (sts.out_free) begin
                    cmd.load_fail = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

endmodule

// File: design/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Bitmap memories, scan pipeline, config registers and result register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
    parameter int POOL_DEPTH        = 4096,
    parameter int MAX_REQUEST_PAGES = 64,
    parameter int PAGE_BYTES        = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bpa_pkg::ADDR_W-1:0]     cfg_wr_data,
    input  logic [bpa_pkg::COUNT_W-1:0]    s_page_count,
    input  logic                           s_user_request,
    output logic [bpa_pkg::ADDR_W-1:0]     m_virt_page_addr,
    output logic [bpa_pkg::ADDR_W-1:0]     m_phys_page_addr,
    output logic                           m_failed,
    output logic                           m_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    input  bpa_pkg::cmd_t                  cmd,
    output bpa_pkg::sts_t                  sts
);
    import bpa_pkg::*;

    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > POOL_W) ? CNT_W : POOL_W;

    // config
    logic [ADDR_W-1:0] phys_base_reg, virt_base_reg;
    logic [POOL_W-1:0] pool_pages_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phys_base_reg  <= PHYS_BASE_RST;
            virt_base_reg  <= VIRT_BASE_RST;
            pool_pages_reg <= POOL_PAGES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PHYS_BASE:  phys_base_reg  <= cfg_wr_data;
                REG_VIRT_BASE:  virt_base_reg  <= cfg_wr_data;
                REG_POOL_PAGES: pool_pages_reg <= cfg_wr_data[POOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] usable;
    assign usable = (CMP_W'(pool_pages_reg) < CMP_W'(POOL_DEPTH)) ?
                    CNT_W'(pool_pages_reg) : CNT_W'(POOL_DEPTH);

    // request
    logic [COUNT_W-1:0] count_reg;
    logic               user_reg;
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            count_reg <= s_page_count;
            user_reg  <= s_user_request;
        end
    end
    assign sts.req_bad = user_reg || (count_reg == '0) ||
                         (count_reg > COUNT_W'(MAX_REQUEST_PAGES));

    // clearing pass
    logic [IDX_W-1:0] clr_addr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)     clr_addr_reg <= '0;
        else if (cmd.clr) clr_addr_reg <= clr_addr_reg + 1'b1;
    end
    assign sts.clr_done = (clr_addr_reg == IDX_W'(POOL_DEPTH - 1));

    // scan pipeline: address stage, then read data stage
    logic [CNT_W-1:0]   scan_addr_reg, hint_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               virt_rd_reg, phys_rd_reg;
    logic [COUNT_W-1:0] run_reg;
    logic [IDX_W-1:0]   vstart_reg, pidx_reg;
    logic [COUNT_W-1:0] mk_reg, page_reg;
    logic               scanning, issue, v_hit, p_hit;

    assign scanning = cmd.scan_v || cmd.scan_p;
    assign issue    = scanning && (scan_addr_reg < usable);
    assign v_hit    = cmd.scan_v && rd_vld_reg && !virt_rd_reg &&
                      (run_reg + 1'b1 == count_reg);
    assign p_hit    = cmd.scan_p && rd_vld_reg && !phys_rd_reg;

    assign sts.v_found = v_hit;
    assign sts.p_found = p_hit;
    assign sts.v_end   = !rd_vld_reg && !(scan_addr_reg < usable);
    assign sts.p_end   = sts.v_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (cmd.start_v || cmd.start_p) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg <= '0;
        end else if (cmd.take_p) begin
            hint_reg <= CNT_W'(pidx_reg) + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_v) begin
            scan_addr_reg <= '0;
            run_reg       <= '0;
        end else if (cmd.start_p) begin
            scan_addr_reg <= hint_reg;
        end else if (issue) begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (issue) rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
        if (cmd.scan_v && rd_vld_reg) begin
            run_reg <= virt_rd_reg ? '0 : run_reg + 1'b1;
        end
        if (v_hit) vstart_reg <= rd_idx_reg - IDX_W'(count_reg) + 1'b1;
        if (p_hit) pidx_reg <= rd_idx_reg;
    end

    // marking and page counters
    always_ff @(posedge aclk) begin
        if (cmd.start_v)     mk_reg <= '0;
        else if (cmd.mark_v) mk_reg <= mk_reg + 1'b1;
        if (cmd.start_v)     page_reg <= '0;
        else if (cmd.take_p) page_reg <= page_reg + 1'b1;
    end
    assign sts.mark_done = (mk_reg + 1'b1 == count_reg);
    assign sts.last_page = (page_reg + 1'b1 == count_reg);

    // bitmap memories
    logic virt_map [POOL_DEPTH];
    logic phys_map [POOL_DEPTH];
    logic [IDX_W-1:0] virt_wa, phys_wa;

    assign virt_wa = cmd.clr ? clr_addr_reg : vstart_reg + IDX_W'(mk_reg);
    assign phys_wa = cmd.clr ? clr_addr_reg : pidx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr || cmd.mark_v) virt_map[virt_wa] <= !cmd.clr;
        virt_rd_reg <= virt_map[scan_addr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr || cmd.take_p) phys_map[phys_wa] <= !cmd.clr;
        phys_rd_reg <= phys_map[scan_addr_reg[IDX_W-1:0]];
    end

    // result register
    logic [IDX_W-1:0]  vidx;
    logic [ADDR_W-1:0] virt_off, phys_off;
    logic              m_valid_reg;

    assign vidx     = vstart_reg + IDX_W'(page_reg);
    assign virt_off = ADDR_W'(vidx) * ADDR_W'(PAGE_BYTES);
    assign phys_off = ADDR_W'(pidx_reg) * ADDR_W'(PAGE_BYTES);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.take_p || cmd.load_fail) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_p) begin
            m_virt_page_addr <= virt_base_reg + virt_off;
            m_phys_page_addr <= phys_base_reg + phys_off;
            m_failed         <= 1'b0;
            m_last           <= sts.last_page;
        end else if (cmd.load_fail) begin
            m_virt_page_addr <= '0;
            m_phys_page_addr <= '0;
            m_failed         <= 1'b1;
            m_last           <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: design/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the bitmap page allocator.
// ----------------------------------------------------------------------------
module bpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_virt_page_addr,
    input logic [31:0] m_phys_page_addr,
    input logic        m_failed,
    input logic        m_last
);
    // failure carries zero addresses
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failed |-> (m_virt_page_addr == '0) && (m_phys_page_addr == '0))
        else $error("failed result with nonzero address");

    // failure always ends a request
    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failed |-> m_last)
        else $error("failed result without last");

    // no new request while a request is still emitting pages
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("request taken mid-request");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_virt_page_addr) && $stable(m_last))
        else $error("stalled result changed");

    // nothing out right after reset
    a_rst: assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_virt_page_addr (m_virt_page_addr),
    .m_phys_page_addr (m_phys_page_addr),
    .m_failed         (m_failed),
    .m_last           (m_last)
);

// File: verif/bitmap_page_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Drives page requests through the allocator, predicts the virtual/physical
// page pairs with a bitmap model of its own, and checks every result in
// order. Covers bad counts, user requests, full pools, a zero pool, address
// wrap and random traffic over growing pool sizes, mostly with random idling.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int MAX_PAGES = 64;
    localparam int PAGE_SZ   = 4096;
    localparam int STALL_LIM = 60000;

    typedef struct {
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] pa;
        logic              failed;
        logic              last;
    } page_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_PHYS_BASE;
    logic [ADDR_W-1:0]    cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [COUNT_W-1:0]   s_page_count = '0;
    logic                 s_user_request = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ADDR_W-1:0]    m_virt_page_addr;
    logic [ADDR_W-1:0]    m_phys_page_addr;
    logic                 m_failed;
    logic                 m_last;

    // model state
    bit                   virt_map [DEPTH];
    bit                   phys_map [DEPTH];
    logic [ADDR_W-1:0]    phys_base_q = PHYS_BASE_RST;
    logic [ADDR_W-1:0]    virt_base_q = VIRT_BASE_RST;
    logic [POOL_W-1:0]    pool_q = POOL_PAGES_RST;
    page_result_t         pending_pages[$];

    int                   err_count = 0;
    int                   quiet_cycles = 0;
    bit                   idle_on = 1'b1;

    bitmap_page_allocator uut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int lowest_run(input bit is_virt, input int n, input int len);
        int run;
        run = 0;
        for (int i = 0; i < n; i++) begin
            if (is_virt ? virt_map[i] : phys_map[i]) begin
                run = 0;
            end else begin
                run++;
                if (run == len) return i + 1 - len;
            end
        end
        return -1;
    endfunction

    function automatic void allocate_pages(input int count, input bit user);
        page_result_t r;
        int n, vstart, p;
        n = (pool_q < DEPTH) ? int'(pool_q) : DEPTH;
        r = '{va: '0, pa: '0, failed: 1'b1, last: 1'b1};
        if (user || count == 0 || count > MAX_PAGES) begin
            pending_pages.push_back(r);
            return;
        end
        vstart = lowest_run(1'b1, n, count);
        if (vstart < 0) begin
            pending_pages.push_back(r);
            return;
        end
        for (int i = 0; i < count; i++) virt_map[vstart + i] = 1'b1;
        for (int i = 0; i < count; i++) begin
            p = lowest_run(1'b0, n, 1);
            if (p < 0) begin
                r = '{va: '0, pa: '0, failed: 1'b1, last: 1'b1};
                pending_pages.push_back(r);
                return;
            end
            phys_map[p] = 1'b1;
            r.va = virt_base_q + ADDR_W'(vstart + i) * ADDR_W'(PAGE_SZ);
            r.pa = phys_base_q + ADDR_W'(p) * ADDR_W'(PAGE_SZ);
            r.failed = 1'b0;
            r.last = (i + 1 == count);
            pending_pages.push_back(r);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        page_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pages.size() == 0) begin
                report("result with nothing pending");
            end else begin
                e = pending_pages.pop_front();
                if (m_virt_page_addr !== e.va)
                    report($sformatf("virt %h want %h", m_virt_page_addr, e.va));
                if (m_phys_page_addr !== e.pa)
                    report($sformatf("phys %h want %h", m_phys_page_addr, e.pa));
                if (m_failed !== e.failed)
                    report($sformatf("failed %b want %b", m_failed, e.failed));
                if (m_last !== e.last)
                    report($sformatf("last %b want %b", m_last, e.last));
            end
        end
    end

    // watchdog: cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIM) begin
                $display("bitmap_page_allocator_tb: errors");
                $finish;
            end
        end
    end

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_PHYS_BASE: phys_base_q = data;
            REG_VIRT_BASE: virt_base_q = data;
            REG_POOL_PAGES: pool_q = data[POOL_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic setup(input logic [ADDR_W-1:0] pb, input logic [ADDR_W-1:0] vb,
                         input logic [ADDR_W-1:0] pool);
        write_cfg(REG_PHYS_BASE, pb);
        write_cfg(REG_VIRT_BASE, vb);
        write_cfg(REG_POOL_PAGES, pool);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(input int count, input bit user);
        while (idle_on && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_page_count <= COUNT_W'(count);
        s_user_request <= user;
        do @(posedge aclk); while (!s_ready);
        allocate_pages(count, user);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pages.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic test_limits();
        setup(32'h0000_0000, 32'hFFFF_F000, 16);
        send_request(0, 1'b0);
        send_request(65, 1'b0);
        send_request(127, 1'b0);
        send_request(5, 1'b1);
        send_request(0, 1'b1);
        send_request(1, 1'b0);
        send_request(16, 1'b0);  // only 15 left
        send_request(15, 1'b0);  // fills the pool
        send_request(1, 1'b0);   // pool full
        drain();
        setup(32'hFFFF_F000, 32'h0000_0000, 0);
        send_request(1, 1'b0);
        send_request(64, 1'b0);
        drain();
    endtask

    task automatic test_wrap();
        setup(32'hFFFF_F000, 32'hFFFF_F000, 40);
        send_request(3, 1'b0);   // indexes from bit 16 wrap the sum
        send_request(64, 1'b0);  // larger than the pool
        send_request(21, 1'b0);
        drain();
        setup(32'h0000_0000, 32'h0000_0000, 8191);
        send_request(64, 1'b0);
        send_request(2, 1'b0);
        drain();
    endtask

    task automatic test_random(input int items, input logic [ADDR_W-1:0] pool, input bit idles);
        int r, count;
        bit user;
        idle_on = idles;
        setup($urandom() & 32'hFFFF_F000, $urandom() & 32'hFFFF_F000, pool);
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            user = 1'b0;
            if (r < 10) begin
                user = 1'b1;
                count = $urandom_range(127);
            end else if (r < 15) begin
                count = $urandom_range(1) ? 0 : $urandom_range(127, 65);
            end else if (r < 25) begin
                count = $urandom_range(64, 9);
            end else begin
                count = $urandom_range(8, 1);
            end
            send_request(count, user);
        end
        drain();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!s_ready);  // wait out the map clear
        test_limits();
        test_wrap();
        test_random(120, 300, 1'b1);
        test_random(60, 1024, 1'b0);
        test_random(80, 2048, 1'b1);
        test_random(40, 8191, 1'b1);
        if (err_count == 0 && pending_pages.size() == 0) begin
            $display("bitmap_page_allocator_tb: clean");
        end else begin
            $display("bitmap_page_allocator_tb: errors");
        end
        $finish;
    end

endmodule
